FILE: rtl/core/btn_pkg.sv
`default_nettype none
package btn_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int VECTOR_BITS_DEF = 32;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STEPS = 30;
  localparam int PHASE_BITS = 32;
  // CORDIC datapath width, with headroom bits above the fraction.
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] t;
    t = '0;
    case (i)
      0: t = 34'sh020000000;  1: t = 34'sh012E4051D;  2: t = 34'sh009FB385B;
      3: t = 34'sh0051111D4;  4: t = 34'sh0028B0D43;  5: t = 34'sh00145D7E1;
      6: t = 34'sh000A2F61E;  7: t = 34'sh000517C55;  8: t = 34'sh00028BE53;
      9: t = 34'sh000145F2F; 10: t = 34'sh0000A2F98; 11: t = 34'sh0000517CC;
      12: t = 34'sh000028BE6; 13: t = 34'sh0000145F3; 14: t = 34'sh00000A2F9;
      15: t = 34'sh00000517D; 16: t = 34'sh0000028BE; 17: t = 34'sh00000145F;
      18: t = 34'sh000000A30; 19: t = 34'sh000000518; 20: t = 34'sh00000028C;
      21: t = 34'sh000000146; 22: t = 34'sh0000000A3; 23: t = 34'sh000000051;
      24: t = 34'sh000000029; 25: t = 34'sh000000014; 26: t = 34'sh00000000A;
      27: t = 34'sh000000005; 28: t = 34'sh000000003; 29: t = 34'sh000000001;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/btn_cordic_lane.sv
`default_nettype none
// One pipelined rotation-mode CORDIC lane: one stage per iteration.
module btn_cordic_lane #(
  parameter int ANGLE_BITS = btn_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = btn_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ANGLE_BITS-1:0]         angle,
  output logic signed [TRIG_FRAC_BITS:0]     sin_o,
  output logic signed [TRIG_FRAC_BITS:0]     cos_o
);
  localparam int N = btn_pkg::CORDIC_STEPS;
  localparam int CW = btn_pkg::CW;
  localparam int SH = 30 - TRIG_FRAC_BITS;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [CW-1:0] z_r [N+1];
  logic                 neg_r [N+1];
  logic [31:0] ph;
  logic [31:0] php;
  logic        nq;

  always_comb begin
    ph = {angle, {(32-ANGLE_BITS){1'b0}}};
    php = ph + 32'h4000_0000;
    nq = php[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= btn_pkg::CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= CW'(signed'({ph[31] ^ nq, ph[30:0]}));
      neg_r[0] <= nq;
      for (int i = 0; i < N; i++) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - btn_pkg::atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + btn_pkg::atan_turn(i);
        end
      end
    end
  end

  function automatic logic signed [TRIG_FRAC_BITS:0] tround(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] top;
    r = (v + (CW'(1) <<< (SH-1))) >>> SH;
    top = (CW'(1) <<< TRIG_FRAC_BITS) - CW'(1);
    if (r > top) r = top;
    if (r < -top - CW'(1)) r = -top - CW'(1);
    return r[TRIG_FRAC_BITS:0];
  endfunction

  logic signed [CW-1:0] xf, yf;
  always_comb begin
    xf = neg_r[N] ? -x_r[N] : x_r[N];
    yf = neg_r[N] ? -y_r[N] : y_r[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= tround(xf);
      sin_o <= tround(yf);
    end
  end

  logic unused;
  assign unused = ^z_r[N];
endmodule
`default_nettype wire

FILE: rtl/core/btn_rotate.sv
`default_nettype none
// Builds the ZYX matrix from the three lanes and merges them into the rotated vector.
module btn_rotate #(
  parameter int VECTOR_BITS = btn_pkg::VECTOR_BITS_DEF,
  parameter int TRIG_FRAC_BITS = btn_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [TRIG_FRAC_BITS:0] sph, cph, sth, cth, sps, cps,
  input  wire logic signed [VECTOR_BITS-1:0] vx, vy, vz,
  output logic signed [VECTOR_BITS-1:0]      n_o, e_o, d_o,
  output logic                               ovf_o
);
  localparam int F = TRIG_FRAC_BITS;
  localparam int TW = F + 3;
  localparam int PW = VECTOR_BITS + TW + 2;

  function automatic logic signed [TW-1:0] mt(input logic signed [TW-1:0] a,
                                              input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = (a * b + (2*TW)'(1 <<< (F-1))) >>> F;
    return p[TW-1:0];
  endfunction

  // Stage 1: cross terms.
  logic signed [TW-1:0] cs_r, ss_r, m00_r, m10_r, m20_r, m21_r, m22_r;
  logic signed [TW-1:0] a_r, b_r, c_r, d_r, sph1_r, cph1_r;
  logic signed [VECTOR_BITS-1:0] v1_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= mt(TW'(cps), TW'(sth));
      ss_r <= mt(TW'(sps), TW'(sth));
      m00_r <= mt(TW'(cps), TW'(cth));
      m10_r <= mt(TW'(sps), TW'(cth));
      m20_r <= -TW'(sth);
      m21_r <= mt(TW'(cth), TW'(sph));
      m22_r <= mt(TW'(cth), TW'(cph));
      a_r <= mt(TW'(sps), TW'(cph));
      b_r <= mt(TW'(sps), TW'(sph));
      c_r <= mt(TW'(cps), TW'(cph));
      d_r <= mt(TW'(cps), TW'(sph));
      sph1_r <= TW'(sph);
      cph1_r <= TW'(cph);
      v1_r[0] <= vx; v1_r[1] <= vy; v1_r[2] <= vz;
    end
  end

  // Stage 2: full matrix.
  logic signed [TW-1:0] m_r [9];
  logic signed [VECTOR_BITS-1:0] v2_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m00_r;
      m_r[1] <= -a_r + mt(cs_r, sph1_r);
      m_r[2] <= b_r + mt(cs_r, cph1_r);
      m_r[3] <= m10_r;
      m_r[4] <= c_r + mt(ss_r, sph1_r);
      m_r[5] <= -d_r + mt(ss_r, cph1_r);
      m_r[6] <= m20_r;
      m_r[7] <= m21_r;
      m_r[8] <= m22_r;
      v2_r <= v1_r;
    end
  end

  // Stage 3: nine rounded products.
  logic signed [PW-1:0] p_r [9];
  logic signed [PW+F-1:0] full [9];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        full[3*r+c] = PW'(v2_r[c]) * (PW+F)'(m_r[3*r+c]) + (PW+F)'(1 <<< (F-1));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) p_r[k] <= PW'(full[k] >>> F);
    end
  end

  // Stage 4: sums and saturation.
  logic signed [PW-1:0] top, sum [3];
  logic [2:0] sat;
  logic signed [VECTOR_BITS-1:0] res [3];
  always_comb begin
    top = (PW'(1) <<< (VECTOR_BITS-1)) - PW'(1);
    for (int r = 0; r < 3; r++) begin
      sum[r] = p_r[3*r] + p_r[3*r+1] + p_r[3*r+2];
      sat[r] = 1'b0;
      res[r] = sum[r][VECTOR_BITS-1:0];
      if (sum[r] > top) begin
        sat[r] = 1'b1; res[r] = top[VECTOR_BITS-1:0];
      end else if (sum[r] < -top - PW'(1)) begin
        sat[r] = 1'b1; res[r] = ~top[VECTOR_BITS-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_o <= res[0]; e_o <= res[1]; d_o <= res[2];
      ovf_o <= |sat;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/body_to_ned_vector_rotation.sv
`default_nettype none
// Channel   Dir  Payload
// in_*      in   tdata: roll, pitch, yaw, body_x, body_y, body_z (low bit up)
// out_*     out  tdata: north, east, down, overflow (low bit up)
//
// One item per cycle while the output is not stalled; the pipeline has one phase fold
// stage, 30 CORDIC stages, one trig rounding stage and four matrix and product stages.
// The whole pipeline advances together and stops while out_tvalid is high
// and out_tready is low, so in_tready follows that condition.
// Reset clears only the per-stage valid bits.
module body_to_ned_vector_rotation #(
  parameter int ANGLE_BITS = btn_pkg::ANGLE_BITS_DEF,
  parameter int VECTOR_BITS = btn_pkg::VECTOR_BITS_DEF,
  parameter int TRIG_FRAC_BITS = btn_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // roll, pitch, yaw, body_x, body_y, body_z
  input  wire logic [((3*ANGLE_BITS+3*VECTOR_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // north, east, down, overflow
  output logic [((3*VECTOR_BITS+1+7)/8)*8-1:0] out_tdata
);
  localparam int LAT = btn_pkg::CORDIC_STEPS + 6;
  localparam int A = ANGLE_BITS;
  localparam int V = VECTOR_BITS;
  localparam int OW = ((3*V+1+7)/8)*8;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  logic signed [TRIG_FRAC_BITS:0] s [3];
  logic signed [TRIG_FRAC_BITS:0] c [3];
  for (genvar l = 0; l < 3; l++) begin : g_lane
    btn_cordic_lane #(.ANGLE_BITS(A), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .angle(in_tdata[l*A +: A]), .sin_o(s[l]), .cos_o(c[l]));
  end

  // Vector delayed to line up with the trig outputs.
  logic [3*V-1:0] vd_r [btn_pkg::CORDIC_STEPS+2];
  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= in_tdata[3*A +: 3*V];
      for (int i = 1; i < btn_pkg::CORDIC_STEPS+2; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  logic signed [V-1:0] n, e, d;
  logic ovf;
  btn_rotate #(.VECTOR_BITS(V), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot (
    .clk(clk), .en(en),
    .sph(s[0]), .cph(c[0]), .sth(s[1]), .cth(c[1]), .sps(s[2]), .cps(c[2]),
    .vx(vd_r[btn_pkg::CORDIC_STEPS+1][0 +: V]),
    .vy(vd_r[btn_pkg::CORDIC_STEPS+1][V +: V]),
    .vz(vd_r[btn_pkg::CORDIC_STEPS+1][2*V +: V]),
    .n_o(n), .e_o(e), .d_o(d), .ovf_o(ovf));

  assign out_tdata = OW'({ovf, d, e, n});

  logic unused;
  assign unused = ^in_tdata;

  // The pipeline never moves while a result is held back.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  // The input side is ready exactly when the pipeline is free to advance.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3*V] |-> 1'b1) else $error("sat");
endmodule
`default_nettype wire
